// File: rtl/core/esc_pkg.sv
// ----------------------------------------------------------------------------
// esc_pkg
// shared types, codes and constants of the elevator scan controller
// ----------------------------------------------------------------------------
`default_nettype none

package esc_pkg;

    localparam int FLOORS_DEF = 8;
    localparam int FLOORS_MAX = 16;

    localparam int KEY_W       = 3;
    localparam int SPEED_W     = 10;
    localparam int DIST_W      = 5;
    localparam int PROD_W      = 14;
    localparam int SUM_W       = 12;
    localparam int STOP_W      = 5;
    localparam int FLOOR_OUT_W = 4;
    localparam int MASK_OUT_W  = 8;
    localparam int TICK_W      = 16;
    localparam int GAIN_W      = 8;
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;

    localparam logic [KEY_W-1:0] KEY_NONE    = 3'd0;
    localparam logic [KEY_W-1:0] KEY_UP      = 3'd1;
    localparam logic [KEY_W-1:0] KEY_DOWN    = 3'd2;
    localparam logic [KEY_W-1:0] KEY_REQUEST = 3'd3;
    localparam logic [KEY_W-1:0] KEY_CANCEL  = 3'd4;

    localparam logic [1:0] REG_TRAVEL = 2'd0;
    localparam logic [1:0] REG_DWELL  = 2'd1;
    localparam logic [1:0] REG_GAIN   = 2'd2;
    localparam logic [1:0] REG_BASE   = 2'd3;

    localparam logic [TICK_W-1:0] TRAVEL_RST = 16'd20;
    localparam logic [TICK_W-1:0] DWELL_RST  = 16'd30;
    localparam logic [GAIN_W-1:0] GAIN_RST   = 8'd50;
    localparam logic [GAIN_W-1:0] BASE_RST   = 8'd40;

    localparam logic [STOP_W-1:0] NO_STOP = 5'h1F;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_UP    = 2'd1,
        MODE_DOWN  = 2'd2,
        MODE_DWELL = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK,
        ST_SCAN,
        ST_MULT,
        ST_UPDATE,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// File: rtl/core/esc_speed.sv
// ----------------------------------------------------------------------------
// esc_speed
// motor drive: registered distance times gain, floor shift, base, saturation
// ----------------------------------------------------------------------------
`default_nettype none

module esc_speed (
    input  wire logic                                aclk,
    input  wire logic                                load,
    input  wire logic signed [esc_pkg::DIST_W-1:0]   delta,
    input  wire logic        [esc_pkg::GAIN_W-1:0]   gain,
    input  wire logic        [esc_pkg::GAIN_W-1:0]   base,
    input  wire logic                                rising,
    output logic      signed [esc_pkg::SPEED_W-1:0]  speed
);

    localparam int SW = esc_pkg::SUM_W;
    localparam logic signed [SW-1:0] SPD_MAX = SW'((1 << (esc_pkg::SPEED_W - 1)) - 1);
    localparam logic signed [SW-1:0] SPD_MIN = -SW'(1 << (esc_pkg::SPEED_W - 1));

    logic signed [esc_pkg::PROD_W-1:0] prod_reg;
    logic signed [esc_pkg::PROD_W-1:0] prod_next;
    logic signed [esc_pkg::GAIN_W:0]   gain_s;
    logic signed [SW-1:0]              shr_s;
    logic signed [SW-1:0]              base_s;
    logic signed [SW-1:0]              sum_s;

    assign gain_s    = $signed({1'b0, gain});
    assign prod_next = load ? delta * gain_s : prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    // arithmetic shift rounds toward minus infinity
    assign shr_s  = SW'(prod_reg >>> 3);
    assign base_s = $signed({{(SW - esc_pkg::GAIN_W){1'b0}}, base});
    assign sum_s  = rising ? shr_s + base_s : shr_s - base_s;

    always_comb begin
        if (sum_s > SPD_MAX) begin
            speed = SPD_MAX[esc_pkg::SPEED_W-1:0];
        end else if (sum_s < SPD_MIN) begin
            speed = SPD_MIN[esc_pkg::SPEED_W-1:0];
        end else begin
            speed = sum_s[esc_pkg::SPEED_W-1:0];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/elevator_scan_controller_unit.sv
// ----------------------------------------------------------------------------
// elevator_scan_controller_unit
// one control tick per request: key handling, wrapping floor scan, motor drive
// ----------------------------------------------------------------------------
//  channel   ports                       direction  content
//  s_        s_valid s_ready s_key_event in         one tick with optional key
//  m_        m_valid m_ready m_*         out        controller status per tick
//  apb       psel penable pwrite paddr.. in/out     four timing and drive regs
//
//  dwelling or with no floor pending, a request runs idle, tick, done;
//  else idle, tick, scan, mult, update, done, the scan stepping past k
//  floors (0 to FLOORS-1) before a pending one, one floor per cycle. the
//  next request is taken while the result register still waits on m_ready.
//  aresetn is synchronous: regs to defaults, all but scan and result cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module elevator_scan_controller_unit #(
    parameter int FLOORS = esc_pkg::FLOORS_DEF
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,

    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic        [esc_pkg::KEY_W-1:0]       s_key_event,

    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic signed      [esc_pkg::SPEED_W-1:0]     m_motor_speed,
    output logic                                        m_lamp_running,
    output logic             [1:0]                      m_motion_mode,
    output logic             [esc_pkg::FLOOR_OUT_W-1:0] m_cabin_floor,
    output logic signed      [esc_pkg::STOP_W-1:0]      m_next_stop,
    output logic             [esc_pkg::FLOOR_OUT_W-1:0] m_selected_floor,
    output logic             [esc_pkg::MASK_OUT_W-1:0]  m_pending_requests,

    input  wire logic                                   psel,
    input  wire logic                                   penable,
    input  wire logic                                   pwrite,
    input  wire logic        [esc_pkg::ADDR_W-1:0]      paddr,
    input  wire logic        [esc_pkg::DATA_W-1:0]      pwdata,
    output logic             [esc_pkg::DATA_W-1:0]      prdata,
    output logic                                        pready
);

    localparam int IW = (FLOORS > 1) ? $clog2(FLOORS) : 1;
    localparam logic [IW-1:0] TOP_IDX = IW'(FLOORS - 1);
    localparam int TW = esc_pkg::TICK_W;
    localparam int GW = esc_pkg::GAIN_W;

    esc_pkg::state_t state_reg, state_next;
    esc_pkg::mode_t  mode_reg, mode_next;

    logic [TW-1:0]     travel_reg, travel_next;
    logic [TW-1:0]     dwell_reg, dwell_next;
    logic [GW-1:0]     gain_reg, gain_next;
    logic [GW-1:0]     base_reg, base_next;

    logic [IW-1:0]     sel_reg, sel_next;
    logic [IW-1:0]     cabin_reg, cabin_next;
    logic [IW-1:0]     scan_reg, scan_next;
    logic [IW-1:0]     target_reg, target_next;
    logic [FLOORS-1:0] mask_reg, mask_next;
    logic [esc_pkg::STOP_W-1:0]  stop_reg, stop_next;
    logic [TW-1:0]     tick_reg, tick_next;
    logic signed [esc_pkg::SPEED_W-1:0] speed_reg, speed_next;
    logic              lamp_reg, lamp_next;

    logic              m_valid_reg, m_valid_next;
    logic signed [esc_pkg::SPEED_W-1:0]     out_speed_reg, out_speed_next;
    logic                                   out_lamp_reg, out_lamp_next;
    logic [1:0]                             out_mode_reg, out_mode_next;
    logic [esc_pkg::FLOOR_OUT_W-1:0]        out_cabin_reg, out_cabin_next;
    logic [esc_pkg::STOP_W-1:0]             out_stop_reg, out_stop_next;
    logic [esc_pkg::FLOOR_OUT_W-1:0]        out_sel_reg, out_sel_next;
    logic [esc_pkg::MASK_OUT_W-1:0]         out_mask_reg, out_mask_next;

    logic [FLOORS-1:0] sel_bit, cabin_bit;
    logic [TW-1:0]     tick_inc;
    logic [esc_pkg::STOP_W-1:0] cabin_fl, sel_fl;
    logic [esc_pkg::FLOORS_MAX-1:0] mask_wide;
    logic signed [esc_pkg::DIST_W-1:0] floor_delta;
    logic signed [esc_pkg::SPEED_W-1:0] drive;
    logic              speed_load;
    logic              cfg_wr;

    assign sel_bit   = {{(FLOORS - 1){1'b0}}, 1'b1} << sel_reg;
    assign cabin_bit = {{(FLOORS - 1){1'b0}}, 1'b1} << cabin_reg;
    assign tick_inc  = tick_reg + TW'(1);
    assign cabin_fl  = esc_pkg::STOP_W'(cabin_reg) + esc_pkg::STOP_W'(1);
    assign sel_fl    = esc_pkg::STOP_W'(sel_reg) + esc_pkg::STOP_W'(1);
    assign mask_wide = esc_pkg::FLOORS_MAX'(mask_reg);
    assign floor_delta = $signed(esc_pkg::DIST_W'(target_reg))
                       - $signed(esc_pkg::DIST_W'(cabin_reg));
    assign cfg_wr    = psel & penable & pwrite & pready;

    esc_speed u_speed (
        .aclk   (aclk),
        .load   (speed_load),
        .delta  (floor_delta),
        .gain   (gain_reg),
        .base   (base_reg),
        .rising (mode_next == esc_pkg::MODE_UP),
        .speed  (drive)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= esc_pkg::ST_IDLE;
            mode_reg    <= esc_pkg::MODE_IDLE;
            travel_reg  <= esc_pkg::TRAVEL_RST;
            dwell_reg   <= esc_pkg::DWELL_RST;
            gain_reg    <= esc_pkg::GAIN_RST;
            base_reg    <= esc_pkg::BASE_RST;
            sel_reg     <= '0;
            cabin_reg   <= '0;
            mask_reg    <= '0;
            stop_reg    <= esc_pkg::NO_STOP;
            tick_reg    <= '0;
            speed_reg   <= '0;
            lamp_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            mode_reg    <= mode_next;
            travel_reg  <= travel_next;
            dwell_reg   <= dwell_next;
            gain_reg    <= gain_next;
            base_reg    <= base_next;
            sel_reg     <= sel_next;
            cabin_reg   <= cabin_next;
            mask_reg    <= mask_next;
            stop_reg    <= stop_next;
            tick_reg    <= tick_next;
            speed_reg   <= speed_next;
            lamp_reg    <= lamp_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_reg      <= scan_next;
        target_reg    <= target_next;
        out_speed_reg <= out_speed_next;
        out_lamp_reg  <= out_lamp_next;
        out_mode_reg  <= out_mode_next;
        out_cabin_reg <= out_cabin_next;
        out_stop_reg  <= out_stop_next;
        out_sel_reg   <= out_sel_next;
        out_mask_reg  <= out_mask_next;
    end

    always_comb begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        travel_next    = travel_reg;
        dwell_next     = dwell_reg;
        gain_next      = gain_reg;
        base_next      = base_reg;
        sel_next       = sel_reg;
        cabin_next     = cabin_reg;
        scan_next      = scan_reg;
        target_next    = target_reg;
        mask_next      = mask_reg;
        stop_next      = stop_reg;
        tick_next      = tick_reg;
        speed_next     = speed_reg;
        lamp_next      = lamp_reg;
        m_valid_next   = m_valid_reg & ~m_ready;
        out_speed_next = out_speed_reg;
        out_lamp_next  = out_lamp_reg;
        out_mode_next  = out_mode_reg;
        out_cabin_next = out_cabin_reg;
        out_stop_next  = out_stop_reg;
        out_sel_next   = out_sel_reg;
        out_mask_next  = out_mask_reg;
        speed_load     = 1'b0;

        // register writes
        if (cfg_wr) begin
            unique case (paddr[3:2])
                esc_pkg::REG_TRAVEL: travel_next = pwdata[TW-1:0];
                esc_pkg::REG_DWELL:  dwell_next  = pwdata[TW-1:0];
                esc_pkg::REG_GAIN:   gain_next   = pwdata[GW-1:0];
                esc_pkg::REG_BASE:   base_next   = pwdata[GW-1:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            esc_pkg::ST_IDLE: begin
                if (s_valid) begin
                    unique case (s_key_event)
                        esc_pkg::KEY_UP: begin
                            if (sel_reg < TOP_IDX) sel_next = sel_reg + IW'(1);
                        end
                        esc_pkg::KEY_DOWN: begin
                            if (sel_reg != '0) sel_next = sel_reg - IW'(1);
                        end
                        esc_pkg::KEY_REQUEST: begin
                            mask_next = mask_reg | sel_bit;
                        end
                        esc_pkg::KEY_CANCEL: begin
                            // the last pending floor cannot be cancelled
                            if ((mask_reg & ~sel_bit) != '0) mask_next = mask_reg & ~sel_bit;
                        end
                        default: ;
                    endcase
                    state_next = esc_pkg::ST_TICK;
                end
            end
            esc_pkg::ST_TICK: begin
                if (mode_reg == esc_pkg::MODE_DWELL) begin
                    tick_next = tick_inc;
                    if (tick_inc > dwell_reg) begin
                        mode_next = esc_pkg::MODE_IDLE;
                        tick_next = '0;
                    end
                    state_next = esc_pkg::ST_DONE;
                end else if (mask_reg == '0) begin
                    state_next = esc_pkg::ST_DONE;
                end else begin
                    scan_next  = cabin_reg;
                    state_next = esc_pkg::ST_SCAN;
                end
            end
            esc_pkg::ST_SCAN: begin
                if (mask_reg[scan_reg]) begin
                    target_next = scan_reg;
                    state_next  = esc_pkg::ST_MULT;
                end else if (mode_reg == esc_pkg::MODE_DOWN) begin
                    scan_next = (scan_reg == '0) ? TOP_IDX : scan_reg - IW'(1);
                end else begin
                    scan_next = (scan_reg == TOP_IDX) ? '0 : scan_reg + IW'(1);
                end
            end
            esc_pkg::ST_MULT: begin
                speed_load = 1'b1;
                state_next = esc_pkg::ST_UPDATE;
            end
            esc_pkg::ST_UPDATE: begin
                stop_next  = esc_pkg::STOP_W'(target_reg) + esc_pkg::STOP_W'(1);
                state_next = esc_pkg::ST_DONE;
                if (cabin_reg < target_reg) begin
                    mode_next  = esc_pkg::MODE_UP;
                    speed_next = drive;
                    lamp_next  = 1'b1;
                    if (tick_reg > travel_reg) begin
                        cabin_next = cabin_reg + IW'(1);
                        tick_next  = TW'(1);
                    end else begin
                        tick_next = tick_inc;
                    end
                end else if (cabin_reg > target_reg) begin
                    mode_next  = esc_pkg::MODE_DOWN;
                    speed_next = drive;
                    lamp_next  = 1'b1;
                    if (tick_reg > travel_reg) begin
                        cabin_next = cabin_reg - IW'(1);
                        tick_next  = TW'(1);
                    end else begin
                        tick_next = tick_inc;
                    end
                end else begin
                    // arrival
                    mode_next  = esc_pkg::MODE_DWELL;
                    stop_next  = esc_pkg::NO_STOP;
                    speed_next = '0;
                    lamp_next  = 1'b0;
                    mask_next  = mask_reg & ~cabin_bit;
                end
            end
            esc_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    out_speed_next = speed_reg;
                    out_lamp_next  = lamp_reg;
                    out_mode_next  = mode_reg;
                    out_cabin_next = cabin_fl[esc_pkg::FLOOR_OUT_W-1:0];
                    out_stop_next  = stop_reg;
                    out_sel_next   = sel_fl[esc_pkg::FLOOR_OUT_W-1:0];
                    out_mask_next  = mask_wide[esc_pkg::MASK_OUT_W-1:0];
                    state_next     = esc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = esc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        unique case (paddr[3:2])
            esc_pkg::REG_TRAVEL: prdata = esc_pkg::DATA_W'(travel_reg);
            esc_pkg::REG_DWELL:  prdata = esc_pkg::DATA_W'(dwell_reg);
            esc_pkg::REG_GAIN:   prdata = esc_pkg::DATA_W'(gain_reg);
            esc_pkg::REG_BASE:   prdata = esc_pkg::DATA_W'(base_reg);
            default:             prdata = '0;
        endcase
    end

    assign pready             = 1'b1;
    assign s_ready            = (state_reg == esc_pkg::ST_IDLE);
    assign m_valid            = m_valid_reg;
    assign m_motor_speed      = out_speed_reg;
    assign m_lamp_running     = out_lamp_reg;
    assign m_motion_mode      = out_mode_reg;
    assign m_cabin_floor      = out_cabin_reg;
    assign m_next_stop        = $signed(out_stop_reg);
    assign m_selected_floor   = out_sel_reg;
    assign m_pending_requests = out_mask_reg;

endmodule

`default_nettype wire

// File: rtl/core/esc_checker.sv
// ----------------------------------------------------------------------------
// esc_checker
// port-level checks of the elevator scan controller, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module esc_checker (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   s_valid,
    input  wire logic                                   s_ready,
    input  wire logic                                   m_valid,
    input  wire logic                                   m_ready,
    input  wire logic signed [esc_pkg::SPEED_W-1:0]     m_motor_speed,
    input  wire logic                                   m_lamp_running,
    input  wire logic        [1:0]                      m_motion_mode,
    input  wire logic        [esc_pkg::FLOOR_OUT_W-1:0] m_cabin_floor,
    input  wire logic signed [esc_pkg::STOP_W-1:0]      m_next_stop,
    input  wire logic        [esc_pkg::MASK_OUT_W-1:0]  m_pending_requests
);

    // a taken request keeps the input closed for at least the next cycle
    a_busy_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input still open right after a request was taken");

    // lamp is lit exactly while rising or descending
    a_lamp_matches_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_lamp_running == (m_motion_mode == esc_pkg::MODE_UP ||
                                        m_motion_mode == esc_pkg::MODE_DOWN)))
        else $error("lamp disagrees with motion mode");

    // idle or dwelling cabin has no drive and no floor being served
    a_stopped_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_motion_mode == esc_pkg::MODE_IDLE ||
                     m_motion_mode == esc_pkg::MODE_DWELL))
        |-> (m_motor_speed == '0 && m_next_stop == $signed(esc_pkg::NO_STOP)))
        else $error("stopped cabin shows drive or a served floor");

    // stalled result holds
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_cabin_floor) &&
                                   $stable(m_pending_requests)))
        else $error("stalled result changed");

endmodule

bind elevator_scan_controller_unit esc_checker u_esc_checker (.*);

`default_nettype wire

// File: tb/elevator_scan_controller_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// elevator_scan_controller_unit_test
// self-checking bench: key ticks in, controller status out, compared per tick
// ----------------------------------------------------------------------------
//  a clocked driver feeds key events from a backlog that the stimulus process
//  fills. every accepted request is run through a behavioral model of the
//  controller and its status is queued. a clocked monitor pops the oldest
//  status for each accepted result and checks every field. between phases the
//  bench drains, then rewrites the four registers over apb.
// ----------------------------------------------------------------------------

module elevator_scan_controller_unit_test;

    localparam int FLOORS = esc_pkg::FLOORS_DEF;
    localparam logic [esc_pkg::KEY_W-1:0] KEY_UNUSED_FIRST = 3'd5;
    localparam logic [esc_pkg::KEY_W-1:0] KEY_UNUSED_LAST  = 3'd7;

    typedef struct {
        int             speed;
        bit             lamp;
        esc_pkg::mode_t mode;
        int             cabin;
        int             stop;
        int             sel;
        logic [7:0]     pend;
    } car_status_t;

    logic                                   aclk = 1'b0;
    logic                                   aresetn = 1'b0;
    logic                                   s_valid = 1'b0;
    logic                                   s_ready;
    logic [esc_pkg::KEY_W-1:0]              s_key_event = esc_pkg::KEY_NONE;
    logic                                   m_valid;
    logic                                   m_ready = 1'b0;
    logic signed [esc_pkg::SPEED_W-1:0]     m_motor_speed;
    logic                                   m_lamp_running;
    logic [1:0]                             m_motion_mode;
    logic [esc_pkg::FLOOR_OUT_W-1:0]        m_cabin_floor;
    logic signed [esc_pkg::STOP_W-1:0]      m_next_stop;
    logic [esc_pkg::FLOOR_OUT_W-1:0]        m_selected_floor;
    logic [esc_pkg::MASK_OUT_W-1:0]         m_pending_requests;
    logic                                   psel = 1'b0;
    logic                                   penable = 1'b0;
    logic                                   pwrite = 1'b0;
    logic [esc_pkg::ADDR_W-1:0]             paddr = '0;
    logic [esc_pkg::DATA_W-1:0]             pwdata = '0;
    logic [esc_pkg::DATA_W-1:0]             prdata;
    logic                                   pready;

    // model of the controller
    logic [esc_pkg::TICK_W-1:0] travel_lim = esc_pkg::TRAVEL_RST;
    logic [esc_pkg::TICK_W-1:0] dwell_lim  = esc_pkg::DWELL_RST;
    logic [esc_pkg::GAIN_W-1:0] gain_r     = esc_pkg::GAIN_RST;
    logic [esc_pkg::GAIN_W-1:0] base_r     = esc_pkg::BASE_RST;
    int                         sel_floor  = 1;
    int                         car_floor  = 1;
    logic [FLOORS-1:0]          req_mask   = '0;
    int                         stop_floor = -1;
    esc_pkg::mode_t             car_mode   = esc_pkg::MODE_IDLE;
    logic [esc_pkg::TICK_W-1:0] ticks      = '0;
    int                         car_speed  = 0;
    bit                         car_lamp   = 1'b0;

    logic [esc_pkg::KEY_W-1:0]  key_backlog[$];
    car_status_t                car_status_q[$];
    int                         owed = 0;
    int                         keys_queued = 0;
    int                         err_count = 0;
    bit                         idle_en = 1'b0;
    int                         send_gap = 0;
    int                         hold = 0;

    elevator_scan_controller_unit #(
        .FLOORS(FLOORS)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_key_event(s_key_event),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_motor_speed(m_motor_speed),
        .m_lamp_running(m_lamp_running),
        .m_motion_mode(m_motion_mode),
        .m_cabin_floor(m_cabin_floor),
        .m_next_stop(m_next_stop),
        .m_selected_floor(m_selected_floor),
        .m_pending_requests(m_pending_requests),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic int draw_gap();
        int r;
        if (!idle_en) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic void predict_tick(input logic [esc_pkg::KEY_W-1:0] key);
        logic [FLOORS-1:0] sel_bit;
        int                idx;
        bit                found;
        bit                rising;
        int                target;
        int                v;
        car_status_t       st;
        sel_bit = '0;
        sel_bit[sel_floor-1] = 1'b1;
        case (key)
            esc_pkg::KEY_UP: begin
                if (sel_floor < FLOORS) sel_floor++;
            end
            esc_pkg::KEY_DOWN: begin
                if (sel_floor > 1) sel_floor--;
            end
            esc_pkg::KEY_REQUEST: begin
                req_mask = req_mask | sel_bit;
            end
            esc_pkg::KEY_CANCEL: begin
                if ((req_mask & ~sel_bit) != '0) req_mask = req_mask & ~sel_bit;
            end
            default: ;
        endcase

        if (car_mode == esc_pkg::MODE_DWELL) begin
            ticks = ticks + 1'b1;
            if (ticks > dwell_lim) begin
                car_mode = esc_pkg::MODE_IDLE;
                ticks = '0;
            end
        end else if (req_mask != '0) begin
            idx = car_floor - 1;
            found = 1'b0;
            for (int n = 0; n < FLOORS; n++) begin
                if (!found) begin
                    if (req_mask[idx]) found = 1'b1;
                    else if (car_mode == esc_pkg::MODE_DOWN) idx = (idx == 0) ? FLOORS - 1 : idx - 1;
                    else idx = (idx + 1) % FLOORS;
                end
            end
            target = idx + 1;
            stop_floor = target;
            if (car_floor == target) begin
                car_mode = esc_pkg::MODE_DWELL;
                stop_floor = -1;
                car_speed = 0;
                car_lamp = 1'b0;
                req_mask[car_floor-1] = 1'b0;
            end else begin
                rising = car_floor < target;
                car_mode = rising ? esc_pkg::MODE_UP : esc_pkg::MODE_DOWN;
                v = ((target - car_floor) * int'(gain_r)) >>> 3;
                v = rising ? v + int'(base_r) : v - int'(base_r);
                if (v > 511) v = 511;
                if (v < -512) v = -512;
                car_speed = v;
                if (ticks > travel_lim) begin
                    car_floor = rising ? car_floor + 1 : car_floor - 1;
                    ticks = '0;
                end
                ticks = ticks + 1'b1;
                car_lamp = 1'b1;
            end
        end

        st.speed = car_speed;
        st.lamp  = car_lamp;
        st.mode  = car_mode;
        st.cabin = car_floor;
        st.stop  = stop_floor;
        st.sel   = sel_floor;
        st.pend  = req_mask[7:0];
        car_status_q.push_back(st);
    endfunction

    function automatic void check_field(input string field, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            err_count++;
        end
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready) predict_tick(s_key_event);
            if (!s_valid || s_ready) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                    s_valid <= 1'b0;
                end else if (key_backlog.size() != 0) begin
                    s_valid <= 1'b1;
                    s_key_event <= key_backlog.pop_front();
                    send_gap <= draw_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        car_status_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            hold <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (car_status_q.size() == 0) begin
                    $error("status with no request outstanding");
                    err_count++;
                end else begin
                    want = car_status_q.pop_front();
                    check_field("motor_speed", want.speed, int'(m_motor_speed));
                    check_field("lamp_running", want.lamp, m_lamp_running);
                    check_field("motion_mode", want.mode, m_motion_mode);
                    check_field("cabin_floor", want.cabin, m_cabin_floor);
                    check_field("next_stop", want.stop, int'(m_next_stop));
                    check_field("selected_floor", want.sel, m_selected_floor);
                    check_field("pending_requests", want.pend, m_pending_requests);
                    owed--;
                end
            end
            if (hold != 0) begin
                hold <= hold - 1;
                m_ready <= 1'b0;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                hold <= draw_gap();
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic queue_key(input logic [esc_pkg::KEY_W-1:0] key);
        key_backlog.push_back(key);
        owed++;
        keys_queued++;
    endtask

    task automatic wait_idle();
        while (owed != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [esc_pkg::DATA_W-1:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            esc_pkg::REG_TRAVEL: travel_lim = value[esc_pkg::TICK_W-1:0];
            esc_pkg::REG_DWELL:  dwell_lim = value[esc_pkg::TICK_W-1:0];
            esc_pkg::REG_GAIN:   gain_r = value[esc_pkg::GAIN_W-1:0];
            esc_pkg::REG_BASE:   base_r = value[esc_pkg::GAIN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(input int travel, input int dwell, input int gain, input int base);
        write_reg(esc_pkg::REG_TRAVEL, travel);
        write_reg(esc_pkg::REG_DWELL, dwell);
        write_reg(esc_pkg::REG_GAIN, gain);
        write_reg(esc_pkg::REG_BASE, base);
    endtask

    // mostly select-request-wait sequences, the rest raw key noise
    task automatic run_random(input int n, input bit idling);
        int                        start;
        int                        steps;
        logic [esc_pkg::KEY_W-1:0] dir;
        @(negedge aclk);
        idle_en = idling;
        start = keys_queued;
        while (keys_queued - start < n) begin
            if ($urandom_range(0, 9) < 7) begin
                steps = $urandom_range(0, 7);
                dir = $urandom_range(0, 1) ? esc_pkg::KEY_UP : esc_pkg::KEY_DOWN;
                repeat (steps) queue_key(dir);
                queue_key(esc_pkg::KEY_REQUEST);
                if ($urandom_range(0, 4) == 0) queue_key(esc_pkg::KEY_CANCEL);
                repeat ($urandom_range(0, 12)) queue_key(esc_pkg::KEY_NONE);
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    queue_key(esc_pkg::KEY_W'($urandom_range(0, 7)));
                end
            end
        end
        wait_idle();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed ticks at reset settings
        @(negedge aclk);
        idle_en = 1'b1;
        queue_key(esc_pkg::KEY_NONE);
        queue_key(esc_pkg::KEY_DOWN);
        queue_key(esc_pkg::KEY_CANCEL);
        queue_key(esc_pkg::KEY_REQUEST);
        for (int k = KEY_UNUSED_FIRST; k <= KEY_UNUSED_LAST; k++) begin
            queue_key(esc_pkg::KEY_W'(k));
        end
        repeat (FLOORS) queue_key(esc_pkg::KEY_UP);
        queue_key(esc_pkg::KEY_REQUEST);
        queue_key(esc_pkg::KEY_CANCEL);
        queue_key(esc_pkg::KEY_DOWN);
        queue_key(esc_pkg::KEY_REQUEST);
        queue_key(esc_pkg::KEY_CANCEL);
        queue_key(esc_pkg::KEY_REQUEST);
        repeat (4) queue_key(esc_pkg::KEY_NONE);
        wait_idle();

        set_regs(0, 0, 255, 255);
        run_random(350, 1'b1);
        set_regs(1, 2, 0, 0);
        run_random(350, 1'b0);
        set_regs(3, 1, $urandom_range(0, 255), $urandom_range(0, 255));
        run_random(350, 1'b1);
        set_regs(65535, 65535, 1, 1);
        run_random(100, 1'b1);
        set_regs($urandom_range(0, 7), $urandom_range(0, 7),
                 $urandom_range(0, 255), $urandom_range(0, 255));
        run_random(350, 1'b1);
        set_regs(2, 0, 128, 0);
        run_random(350, 1'b1);

        set_regs($urandom_range(0, 4), 2, $urandom_range(0, 255), $urandom_range(0, 255));
        run_random(100, 1'b1);

        wait_idle();
        if (car_status_q.size() != 0) begin
            $error("%0d status results never arrived", car_status_q.size());
            err_count++;
        end
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// File: files.f
rtl/core/esc_pkg.sv
rtl/core/esc_speed.sv
rtl/core/elevator_scan_controller_unit.sv
rtl/core/esc_checker.sv
tb/elevator_scan_controller_unit_test.sv
